FILE: src/sclm_pkg.sv
// Package for the side-channel leakage model unit.
// Holds mode codes, the AES S-box, the test key and the listed offset pairs.
// No dependencies.
package sclm_pkg;

    localparam int KeyBitsDefault = 8;

    localparam logic [1:0] CM_SBOX  = 2'd0;
    localparam logic [1:0] CM_TTAB  = 2'd1;
    localparam logic [1:0] CM_CHAR  = 2'd2;

    localparam logic [1:0] LM_HW    = 2'd0;
    localparam logic [1:0] LM_HD    = 2'd1;
    localparam logic [1:0] LM_HDSUM = 2'd2;

    localparam logic [2:0] OP_NONE  = 3'd0;
    localparam logic [2:0] OP_ADD   = 3'd1;
    localparam logic [2:0] OP_XOR   = 3'd2;
    localparam logic [2:0] OP_AND   = 3'd3;
    localparam logic [2:0] OP_MUL   = 3'd4;
    localparam logic [2:0] OP_XORB  = 3'd5;
    localparam logic [2:0] OP_SHL3  = 3'd6;
    localparam logic [2:0] OP_ADDALL = 3'd7;

    localparam logic [2:0] REG_CIPHER = 3'd0;
    localparam logic [2:0] REG_MODEL  = 3'd1;
    localparam logic [2:0] REG_OFF1   = 3'd2;
    localparam logic [2:0] REG_OFF2   = 3'd3;
    localparam logic [2:0] REG_NBYTES = 3'd4;
    localparam logic [2:0] REG_OP     = 3'd5;
    localparam logic [2:0] REG_KKB    = 3'd6;

    localparam logic [7:0] SBOX [256] = '{
8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] AES_KEY [16] = '{
        8'h2b,8'h7e,8'h15,8'h16,8'h28,8'hae,8'hd2,8'ha6,
        8'hab,8'hf7,8'h15,8'h88,8'h09,8'hcf,8'h4f,8'h3c
    };

    localparam logic [15:0] LISTED_PAIRS [16] = '{
        16'h0022,16'h0845,16'h00CA,16'h0090,16'h0220,16'h0640,16'h0880,16'h0900,
        16'h2200,16'h6400,16'hC808,16'h1000,16'h2042,16'h4006,16'h808C,16'h4009
    };

    // Configuration snapshot carried with each item down the pipeline.
    typedef struct packed {
        logic [1:0] cipher;
        logic [1:0] model;
        logic [3:0] off2;
        logic [2:0] op;
        logic       err;
        logic       addall;
        logic       kb_listed;
    } t_ctl;

    // Substitution: S-box byte or T-table word of the low byte.
    function automatic logic [31:0] subst(input logic [7:0] v, input logic ttab);
        logic [7:0] s;
        logic [7:0] s2;
        s  = SBOX[v];
        s2 = {s[6:0], 1'b0} ^ (s[7] ? 8'h1b : 8'h00);
        if (ttab) subst = {s2 ^ s, s, s, s2};
        else subst = {24'd0, s};
    endfunction

    function automatic logic [5:0] popcnt32(input logic [31:0] v);
        logic [5:0] c;
        c = '0;
        for (int i = 0; i < 32; i++) c = c + {5'd0, v[i]};
        popcnt32 = c;
    endfunction

endpackage

FILE: src/sclm_gather.sv
// Big-endian word gather from a 16-byte plaintext.
// Depends on nothing but its ports.
module sclm_gather (
    input  logic [127:0] i_pt,
    input  logic [3:0]   i_off,
    input  logic [2:0]   i_nbytes,
    output logic [31:0]  o_word
);
    logic [7:0] w_byte [4];

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            logic [4:0] idx;
            idx = {1'b0, i_off} + 5'(i);
            w_byte[i] = idx[4] ? 8'd0 : i_pt[8'd127 - {idx[3:0], 3'd0} -: 8];
        end
        unique case (i_nbytes)
            3'd1:    o_word = {24'd0, w_byte[0]};
            3'd2:    o_word = {16'd0, w_byte[0], w_byte[1]};
            3'd3:    o_word = {8'd0, w_byte[0], w_byte[1], w_byte[2]};
            default: o_word = {w_byte[0], w_byte[1], w_byte[2], w_byte[3]};
        endcase
    end
endmodule

FILE: src/side_channel_leakage_model_unit.sv
// Top level of the side-channel leakage model unit.
// Depends on sclm_pkg and sclm_gather.
//
// Use: write the configuration registers through i_cfg_we / i_cfg_idx /
// i_cfg_data while the unit is idle. Raise start with one plaintext (two
// 64-bit halves) and a key guess; an item is taken at each rising edge
// with start high, and busy is always low, so one item may enter every
// cycle. Each item yields exactly one result on o_power_value and
// o_config_error, marked by o_valid for one cycle.
// Each item passes through a four-stage pipeline: stage one gathers the words
// and settles the mode, stage two applies the key and combine step (including
// the multiply), stage three substitutes and forms the difference words,
// stage four counts bits. Throughput is one item per cycle.
// The receiver cannot stall, so the pipeline never holds.
// Reset clears all valid bits and returns the configuration registers to their reset
// values; items in flight are dropped.
module side_channel_leakage_model_unit #(
    parameter int KEY_BITS = sclm_pkg::KeyBitsDefault
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         start,
    output logic         busy,
    input  logic [63:0]  i_plaintext_high,
    input  logic [63:0]  i_plaintext_low,
    input  logic [7:0]   i_key_guess,
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_idx,
    input  logic [7:0]   i_cfg_data,
    output logic         o_valid,
    output logic [6:0]   o_power_value,
    output logic         o_config_error
);
    // Configuration registers.
    logic [1:0] r_cipher, r_model;
    logic [3:0] r_off1, r_off2;
    logic [2:0] r_nb, r_op;
    logic [7:0] r_kkb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cipher <= sclm_pkg::CM_SBOX;
            r_model  <= sclm_pkg::LM_HW;
            r_off1   <= 4'd0;
            r_off2   <= 4'd2;
            r_nb     <= 3'd1;
            r_op     <= sclm_pkg::OP_NONE;
            r_kkb    <= 8'h2b;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                sclm_pkg::REG_CIPHER: r_cipher <= i_cfg_data[1:0];
                sclm_pkg::REG_MODEL:  r_model  <= i_cfg_data[1:0];
                sclm_pkg::REG_OFF1:   r_off1   <= i_cfg_data[3:0];
                sclm_pkg::REG_OFF2:   r_off2   <= i_cfg_data[3:0];
                sclm_pkg::REG_NBYTES: r_nb     <= i_cfg_data[2:0];
                sclm_pkg::REG_OP:     r_op     <= i_cfg_data[2:0];
                sclm_pkg::REG_KKB:    r_kkb    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;

    logic [127:0] w_pt;
    assign w_pt = {i_plaintext_high, i_plaintext_low};

    // In the sum-of-distances and add-all cases the words sit at fixed
    // offsets; otherwise A and B come from the configured offsets.
    logic w_fixed;
    logic [31:0] w_ga, w_gb, w_g8, w_g12;
    logic [3:0] w_oa, w_ob;

    sclm_pkg::t_ctl w_ctl;
    always_comb begin
        w_ctl.cipher    = r_cipher;
        w_ctl.model     = r_model;
        w_ctl.off2      = r_off2;
        w_ctl.op        = r_op;
        w_ctl.addall    = (r_cipher == sclm_pkg::CM_CHAR) && (r_op == sclm_pkg::OP_ADDALL);
        w_ctl.err       = (r_cipher == 2'd3) || (r_model == 2'd3) || (r_nb == 3'd0)
                          || (r_nb > 3'd4)
                          || (!w_ctl.addall && (r_model == sclm_pkg::LM_HDSUM)
                              && (r_off2 != 4'd8) && (r_off2 != 4'd12));
        w_ctl.kb_listed = sclm_pkg::LISTED_PAIRS[r_off1][r_off2];
    end
    assign w_fixed = w_ctl.addall || (r_model == sclm_pkg::LM_HDSUM);
    assign w_oa = w_fixed ? 4'd0 : r_off1;
    assign w_ob = w_fixed ? 4'd4 : r_off2;

    sclm_gather u_ga  (.i_pt(w_pt), .i_off(w_oa),  .i_nbytes(r_nb), .o_word(w_ga));
    sclm_gather u_gb  (.i_pt(w_pt), .i_off(w_ob),  .i_nbytes(r_nb), .o_word(w_gb));
    sclm_gather u_g8  (.i_pt(w_pt), .i_off(4'd8),  .i_nbytes(r_nb), .o_word(w_g8));
    sclm_gather u_g12 (.i_pt(w_pt), .i_off(4'd12), .i_nbytes(r_nb), .o_word(w_g12));

    // The key guess keeps only its low KEY_BITS bits.
    logic [7:0] w_kmask;
    assign w_kmask = i_key_guess & 8'((32'd1 << KEY_BITS) - 32'd1);

    // Stage 1 registers.
    logic r1_v;
    sclm_pkg::t_ctl r1_ctl;
    logic [31:0] r1_a, r1_b, r1_c, r1_d;
    logic [7:0] r1_k, r1_kb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r1_v <= 1'b0;
        else r1_v <= start;
        r1_ctl <= w_ctl;
        r1_a   <= w_ga;
        r1_b   <= w_gb;
        r1_c   <= w_g8;
        r1_d   <= w_g12;
        r1_k   <= w_kmask;
        r1_kb  <= w_ctl.kb_listed ? sclm_pkg::AES_KEY[r_off1] : r_kkb;
    end

    // Stage 2: key mixing, combine step and the sums for add-all.
    logic [31:0] n2_a, n2_b, n2_c, n2_d;
    always_comb begin
        n2_a = r1_a;
        n2_b = r1_b;
        n2_c = r1_c;
        n2_d = r1_d;
        if (r1_ctl.addall) begin
            n2_a = r1_a + r1_b;
            n2_b = r1_c + r1_d;
        end else if (r1_ctl.model == sclm_pkg::LM_HDSUM) begin
            // words already in place
        end else if (r1_ctl.cipher == sclm_pkg::CM_CHAR) begin
            unique case (r1_ctl.op)
                sclm_pkg::OP_ADD:  n2_a = r1_a + r1_b;
                sclm_pkg::OP_XOR:  n2_a = r1_a ^ r1_b;
                sclm_pkg::OP_AND:  n2_a = r1_a & r1_b;
                sclm_pkg::OP_MUL:  n2_a = 32'(r1_a * r1_b);
                sclm_pkg::OP_XORB: n2_b = r1_a ^ r1_b;
                sclm_pkg::OP_SHL3: begin
                    n2_a = {r1_a[28:0], 3'd0};
                    n2_b = {r1_b[28:0], 3'd0};
                end
                default: ;
            endcase
        end else if (r1_ctl.model == sclm_pkg::LM_HW) begin
            n2_a = r1_a ^ {24'd0, r1_k};
        end else if (r1_ctl.off2 == 4'd0) begin
            n2_b = {24'd0, r1_k};
        end else begin
            n2_a = r1_a ^ {24'd0, r1_kb};
            n2_b = r1_b ^ {24'd0, r1_k};
        end
    end

    logic r2_v;
    sclm_pkg::t_ctl r2_ctl;
    logic [31:0] r2_a, r2_b, r2_c, r2_d;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r2_v <= 1'b0;
        else r2_v <= r1_v;
        r2_ctl <= r1_ctl;
        r2_a <= n2_a;
        r2_b <= n2_b;
        r2_c <= n2_c;
        r2_d <= n2_d;
    end

    // Stage 3: substitution and the words whose bits are counted.
    logic [31:0] n3_x, n3_y, n3_z;
    logic w_aes, w_tt;
    assign w_aes = (r2_ctl.cipher != sclm_pkg::CM_CHAR);
    assign w_tt  = (r2_ctl.cipher == sclm_pkg::CM_TTAB);
    always_comb begin
        n3_y = '0;
        n3_z = '0;
        if (r2_ctl.addall) begin
            n3_x = r2_a ^ r2_b;
        end else if (r2_ctl.model == sclm_pkg::LM_HDSUM) begin
            n3_x = r2_a ^ r2_b;
            n3_y = r2_b ^ r2_c;
            n3_z = (r2_ctl.off2 == 4'd12) ? (r2_c ^ r2_d) : 32'd0;
        end else if (!w_aes) begin
            n3_x = (r2_ctl.model == sclm_pkg::LM_HW) ? r2_a : (r2_a ^ r2_b);
        end else if (r2_ctl.model == sclm_pkg::LM_HW) begin
            n3_x = (r2_ctl.off2 == 4'd0) ? r2_a : sclm_pkg::subst(r2_a[7:0], w_tt);
        end else if (r2_ctl.off2 == 4'd0) begin
            n3_x = r2_a ^ r2_b;
        end else begin
            n3_x = sclm_pkg::subst(r2_a[7:0], w_tt) ^ sclm_pkg::subst(r2_b[7:0], w_tt);
        end
    end

    logic r3_v, r3_err;
    logic [31:0] r3_x, r3_y, r3_z;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r3_v <= 1'b0;
        else r3_v <= r2_v;
        r3_err <= r2_ctl.err;
        r3_x <= n3_x;
        r3_y <= n3_y;
        r3_z <= n3_z;
    end

    // Stage 4: bit counts and their sum.
    logic [6:0] n4_val;
    assign n4_val = r3_err ? 7'd0 : 7'({1'b0, sclm_pkg::popcnt32(r3_x)}
                    + {1'b0, sclm_pkg::popcnt32(r3_y)} + {1'b0, sclm_pkg::popcnt32(r3_z)});

    logic r4_v, r4_err;
    logic [6:0] r4_val;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r4_v <= 1'b0;
        else r4_v <= r3_v;
        r4_err <= r3_err;
        r4_val <= n4_val;
    end

    assign o_valid        = r4_v;
    assign o_power_value  = r4_val;
    assign o_config_error = r4_err;
endmodule
